[rtl/dqt_pkg.sv]
package dqt_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_INV_FOCAL       = 3'd2,
        CFG_INV_WIDTH_SPAN  = 3'd3,
        CFG_INV_HEIGHT_SPAN = 3'd4,
        CFG_MAX_DIFF_RATIO  = 3'd5
    } t_cfg_idx;

    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd1024;
    localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd1024;
    localparam logic [23:0] RST_INV_FOCAL       = 24'd16777;
    localparam logic [23:0] RST_INV_WIDTH_SPAN  = 24'd16400;
    localparam logic [23:0] RST_INV_HEIGHT_SPAN = 24'd16400;
    localparam logic [15:0] RST_MAX_DIFF_RATIO  = 16'd3277;

    // one quad request
    typedef struct packed {
        logic [11:0] quad_col;
        logic [11:0] quad_row;
        logic [15:0] depth_top_left;
        logic [15:0] depth_top_right;
        logic [15:0] depth_bottom_left;
        logic [15:0] depth_bottom_right;
    } t_quad_req;

    // one emitted vertex
    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic [15:0]        vertex_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               last_vertex;
    } t_vertex;

    // corner order of the triangle that leaves out corner t, packed {c0, c1, c2}
    function automatic logic [5:0] tri_corners(input logic [1:0] t);
        logic [5:0] res;
        case (t)
            2'd0:    res = {2'd3, 2'd1, 2'd2};
            2'd1:    res = {2'd0, 2'd2, 2'd3};
            2'd2:    res = {2'd3, 2'd1, 2'd0};
            default: res = {2'd0, 2'd2, 2'd1};
        endcase
        return res;
    endfunction

endpackage

[rtl/depth_quad_triangulator_core.sv]
// depth quad triangulator
// A quad request (column, row, four Q8.8 depths) is taken at a rising edge where
// start is high and busy is low. Each kept triangle gives three vertices on
// o_vertex, one per cycle, each marked by o_valid for one cycle; last_vertex is
// set on the final vertex of the quad. The receiver cannot stall.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data; ready
// is always high. Write only while no quad is in flight.
// A quad's first vertex passes the capture, difference, ratio, sequencer, v1, v2,
// v3 and output registers; the rest follow in consecutive cycles.
// A quad with no kept triangle leaves the ratio stage without waiting; one with kept
// triangles waits there for the vertex sequencer that sends one vertex a cycle, and
// busy rises while the front stages wait on it.
// Front stages: capture, depth differences, ratio products; the vertex path has
// three more stages (offsets, focal products, split depth products) and the
// output register.
// Reset (i_rst_n low, synchronous) empties all stages and loads the register
// reset values.
module depth_quad_triangulator_core #(
    parameter int MAX_DIM    = 4096,
    parameter int DEPTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dqt_pkg::t_quad_req                i_req,
    output logic                              o_valid,
    output dqt_pkg::t_vertex                  o_vertex,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [2:0]                        i_cfg_index,
    input  logic [dqt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DB = (DEPTH_BITS > 16) ? 16 : DEPTH_BITS;
    localparam logic [15:0] DMASK = 16'((17'(1) << DB) - 17'(1));
    localparam logic [14:0] MAXD  = 15'(MAX_DIM);

    // configuration registers
    logic [12:0] r_width, r_height;
    logic [23:0] r_focal, r_inv_w, r_inv_h;
    logic [15:0] r_ratio;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dqt_pkg::RST_IMAGE_WIDTH;
            r_height <= dqt_pkg::RST_IMAGE_HEIGHT;
            r_focal  <= dqt_pkg::RST_INV_FOCAL;
            r_inv_w  <= dqt_pkg::RST_INV_WIDTH_SPAN;
            r_inv_h  <= dqt_pkg::RST_INV_HEIGHT_SPAN;
            r_ratio  <= dqt_pkg::RST_MAX_DIFF_RATIO;
        end else if (i_cfg_valid) begin
            case (dqt_pkg::t_cfg_idx'(i_cfg_index))
                dqt_pkg::CFG_IMAGE_WIDTH:     r_width  <= i_cfg_data[12:0];
                dqt_pkg::CFG_IMAGE_HEIGHT:    r_height <= i_cfg_data[12:0];
                dqt_pkg::CFG_INV_FOCAL:       r_focal  <= i_cfg_data[23:0];
                dqt_pkg::CFG_INV_WIDTH_SPAN:  r_inv_w  <= i_cfg_data[23:0];
                dqt_pkg::CFG_INV_HEIGHT_SPAN: r_inv_h  <= i_cfg_data[23:0];
                dqt_pkg::CFG_MAX_DIFF_RATIO:  r_ratio  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // effective image size
    logic [12:0] eff_w, eff_h;
    assign eff_w = ({2'b0, r_width}  > MAXD) ? 13'(MAXD) : r_width;
    assign eff_h = ({2'b0, r_height} > MAXD) ? 13'(MAXD) : r_height;

    // stage flow control
    logic r_a_valid, r_b_valid, r_c_valid;
    logic a_free, b_free, c_free, c_go, seq_free;
    logic [1:0] c_ntri;
    logic accept;

    assign c_go   = r_c_valid && ((c_ntri == 2'd0) || seq_free);
    assign c_free = !r_c_valid || c_go;
    assign b_free = !r_b_valid || c_free;
    assign a_free = !r_a_valid || b_free;
    assign busy   = !a_free;
    assign accept = start && a_free;

    // stage a: capture request
    logic [11:0] r_a_col, r_a_row;
    logic [15:0] r_a_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_col  <= i_req.quad_col;
            r_a_row  <= i_req.quad_row;
            r_a_d[0] <= i_req.depth_top_left & DMASK;
            r_a_d[1] <= i_req.depth_top_right & DMASK;
            r_a_d[2] <= i_req.depth_bottom_left & DMASK;
            r_a_d[3] <= i_req.depth_bottom_right & DMASK;
        end
    end

    // stage b: pair differences, pair maxima, candidates
    // pairs: 01, 02, 03, 12, 13, 23
    logic [1:0] pa [6];
    logic [1:0] pb [6];
    assign pa[0] = 2'd0; assign pb[0] = 2'd1;
    assign pa[1] = 2'd0; assign pb[1] = 2'd2;
    assign pa[2] = 2'd0; assign pb[2] = 2'd3;
    assign pa[3] = 2'd1; assign pb[3] = 2'd2;
    assign pa[4] = 2'd1; assign pb[4] = 2'd3;
    assign pa[5] = 2'd2; assign pb[5] = 2'd3;

    logic [15:0] n_b_diff [6];
    logic [15:0] n_b_max  [6];
    logic [3:0]  n_b_cand;
    logic [3:0]  a_vld;
    logic [2:0]  a_nvalid;

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            if (r_a_d[pa[p]] > r_a_d[pb[p]]) begin
                n_b_diff[p] = r_a_d[pa[p]] - r_a_d[pb[p]];
                n_b_max[p]  = r_a_d[pa[p]];
            end else begin
                n_b_diff[p] = r_a_d[pb[p]] - r_a_d[pa[p]];
                n_b_max[p]  = r_a_d[pb[p]];
            end
        end
        for (int i = 0; i < 4; i++) begin
            a_vld[i] = (r_a_d[i] != 16'd0);
        end
        a_nvalid = 3'(a_vld[0]) + 3'(a_vld[1]) + 3'(a_vld[2]) + 3'(a_vld[3]);
        if (a_nvalid == 3'd3) begin
            n_b_cand = ~a_vld;
        end else if (a_nvalid == 3'd4) begin
            // diagonal 0-3 against 1-2
            n_b_cand = (n_b_diff[2] > n_b_diff[3]) ? 4'b1001 : 4'b0110;
        end else begin
            n_b_cand = 4'b0000;
        end
    end

    logic [15:0] r_b_diff [6];
    logic [15:0] r_b_max  [6];
    logic [3:0]  r_b_cand;
    logic [11:0] r_b_col, r_b_row;
    logic [15:0] r_b_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_b_diff <= n_b_diff;
            r_b_max  <= n_b_max;
            r_b_cand <= n_b_cand;
            r_b_col  <= r_a_col;
            r_b_row  <= r_a_row;
            r_b_d    <= r_a_d;
        end
    end

    // stage c: ratio products
    logic [31:0] r_c_lhs [6];
    logic [31:0] r_c_rhs [6];
    logic [3:0]  r_c_cand;
    logic [11:0] r_c_col, r_c_row;
    logic [15:0] r_c_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free && r_b_valid) begin
            for (int p = 0; p < 6; p++) begin
                r_c_lhs[p] <= {r_b_diff[p], 16'd0};
                r_c_rhs[p] <= 32'(r_ratio) * 32'(r_b_max[p]);
            end
            r_c_cand <= r_b_cand;
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_d    <= r_b_d;
        end
    end

    // pair test, kept triangles and vertex list
    logic [5:0] pok;
    logic [3:0] kept;
    logic [1:0] t_first, t_second;
    logic [5:0] tri_a, tri_b;

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            pok[p] = r_c_lhs[p] < r_c_rhs[p];
        end
        kept[0] = r_c_cand[0] && pok[3] && pok[4] && pok[5];
        kept[1] = r_c_cand[1] && pok[1] && pok[2] && pok[5];
        kept[2] = r_c_cand[2] && pok[0] && pok[2] && pok[4];
        kept[3] = r_c_cand[3] && pok[0] && pok[1] && pok[3];
        c_ntri  = 2'(kept[0]) + 2'(kept[1]) + 2'(kept[2]) + 2'(kept[3]);
        t_first  = kept[0] ? 2'd0 : kept[1] ? 2'd1 : kept[2] ? 2'd2 : 2'd3;
        t_second = kept[3] ? 2'd3 : kept[2] ? 2'd2 : kept[1] ? 2'd1 : 2'd0;
        tri_a = dqt_pkg::tri_corners(t_first);
        tri_b = dqt_pkg::tri_corners(t_second);
    end

    // vertex sequencer: one vertex per cycle
    logic        r_s_active;
    logic [2:0]  r_s_idx, r_s_last_idx;
    logic [1:0]  r_s_list [6];
    logic [11:0] r_s_col, r_s_row;
    logic [15:0] r_s_d [4];

    assign seq_free = !r_s_active || (r_s_idx == r_s_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_active <= 1'b0;
            r_s_idx    <= 3'd0;
        end else if (c_go && (c_ntri != 2'd0)) begin
            r_s_active <= 1'b1;
            r_s_idx    <= 3'd0;
        end else if (r_s_active) begin
            if (r_s_idx == r_s_last_idx) begin
                r_s_active <= 1'b0;
            end
            r_s_idx <= r_s_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go && (c_ntri != 2'd0)) begin
            r_s_last_idx <= (c_ntri == 2'd2) ? 3'd5 : 3'd2;
            r_s_list[0]  <= tri_a[5:4];
            r_s_list[1]  <= tri_a[3:2];
            r_s_list[2]  <= tri_a[1:0];
            r_s_list[3]  <= tri_b[5:4];
            r_s_list[4]  <= tri_b[3:2];
            r_s_list[5]  <= tri_b[1:0];
            r_s_col      <= r_c_col;
            r_s_row      <= r_c_row;
            r_s_d        <= r_c_d;
        end
    end

    // v1: pixel position and centre offsets, position may reach 4096
    logic [1:0]  s_corner;
    logic [12:0] s_c, s_r;
    logic [13:0] s_p2c, s_p2r;

    always_comb begin
        s_corner = (r_s_idx > 3'd5) ? 2'd0 : r_s_list[r_s_idx];
        s_c      = {1'b0, r_s_col} + 13'(s_corner[0]);
        s_r      = {1'b0, r_s_row} + 13'(s_corner[1]);
        s_p2c    = {s_c, 1'b0};
        s_p2r    = {s_r, 1'b0};
    end

    logic        r_v1_valid, r_v1_last, r_v1_negx, r_v1_negy;
    logic [15:0] r_v1_z;
    logic [13:0] r_v1_n2x, r_v1_n2y;
    logic [12:0] r_v1_c, r_v1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_valid <= 1'b0;
        end else begin
            r_v1_valid <= r_s_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1_last <= (r_s_idx == r_s_last_idx);
        r_v1_z    <= r_s_d[s_corner];
        r_v1_c    <= s_c;
        r_v1_r    <= s_r;
        r_v1_negx <= {1'b0, eff_w} > s_p2c;
        r_v1_negy <= {1'b0, eff_h} > s_p2r;
        r_v1_n2x  <= ({1'b0, eff_w} > s_p2c) ? {1'b0, eff_w} - s_p2c : s_p2c - {1'b0, eff_w};
        r_v1_n2y  <= ({1'b0, eff_h} > s_p2r) ? {1'b0, eff_h} - s_p2r : s_p2r - {1'b0, eff_h};
    end

    // v2: focal and texture products
    logic        r_v2_valid, r_v2_last, r_v2_negx, r_v2_negy;
    logic [15:0] r_v2_z;
    logic [37:0] r_v2_px, r_v2_py;
    logic [36:0] r_v2_tu, r_v2_tv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_valid <= 1'b0;
        end else begin
            r_v2_valid <= r_v1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v2_last <= r_v1_last;
        r_v2_negx <= r_v1_negx;
        r_v2_negy <= r_v1_negy;
        r_v2_z    <= r_v1_z;
        r_v2_px   <= 38'(r_v1_n2x) * 38'(r_focal);
        r_v2_py   <= 38'(r_v1_n2y) * 38'(r_focal);
        r_v2_tu   <= 37'(r_v1_c) * 37'(r_inv_w);
        r_v2_tv   <= 37'(r_v1_r) * 37'(r_inv_h);
    end

    // v3: split depth products, texture rounding
    logic [29:0] tu_full, tv_full;
    logic [16:0] tu_sat, tv_sat;

    always_comb begin
        tu_full = 30'((38'(r_v2_tu) + 38'd128) >> 8);
        tv_full = 30'((38'(r_v2_tv) + 38'd128) >> 8);
        tu_sat  = (tu_full > 30'd65536) ? 17'd65536 : tu_full[16:0];
        tv_sat  = (tv_full > 30'd65536) ? 17'd65536 : tv_full[16:0];
    end

    logic        r_v3_valid, r_v3_last, r_v3_negx, r_v3_negy;
    logic [15:0] r_v3_z;
    logic [34:0] r_v3_xl, r_v3_yl;
    logic [34:0] r_v3_xh, r_v3_yh;
    logic [16:0] r_v3_u, r_v3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3_valid <= 1'b0;
        end else begin
            r_v3_valid <= r_v2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v3_last <= r_v2_last;
        r_v3_negx <= r_v2_negx;
        r_v3_negy <= r_v2_negy;
        r_v3_z    <= r_v2_z;
        r_v3_xl   <= 35'(r_v2_z) * 35'(r_v2_px[18:0]);
        r_v3_xh   <= 35'(r_v2_z) * 35'(r_v2_px[37:19]);
        r_v3_yl   <= 35'(r_v2_z) * 35'(r_v2_py[18:0]);
        r_v3_yh   <= 35'(r_v2_z) * 35'(r_v2_py[37:19]);
        r_v3_u    <= tu_sat;
        r_v3_v    <= 17'd65536 - tv_sat;
    end

    // output: sum partials, round, saturate, sign
    function automatic logic [31:0] finish(input logic [34:0] hi, input logic [34:0] lo,
                                           input logic neg);
        logic [54:0] sum;
        logic [37:0] mag;
        logic [31:0] res;
        sum = 55'({hi, 19'd0}) + 55'(lo) + 55'd65536;
        mag = sum[54:17];
        if (neg) begin
            res = (mag >= 38'h0080000000) ? 32'h80000000 : 32'(~mag[31:0] + 32'd1);
        end else begin
            res = (mag > 38'h007fffffff) ? 32'h7fffffff : mag[31:0];
        end
        return res;
    endfunction

    logic r_o_valid;
    dqt_pkg::t_vertex r_o_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_v3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_vtx.vertex_x    <= finish(r_v3_xh, r_v3_xl, r_v3_negx);
        r_o_vtx.vertex_y    <= finish(r_v3_yh, r_v3_yl, r_v3_negy);
        r_o_vtx.vertex_z    <= r_v3_z;
        r_o_vtx.tex_u       <= r_v3_u;
        r_o_vtx.tex_v       <= r_v3_v;
        r_o_vtx.last_vertex <= r_v3_last;
    end

    assign o_valid  = r_o_valid;
    assign o_vertex = r_o_vtx;

    // checks
    a_seq_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_active |-> (r_s_idx <= r_s_last_idx))
        else $error("sequencer index past end of vertex list");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && busy) |=> (r_a_valid && $stable(r_a_col) && $stable(r_a_row)))
        else $error("stalled quad lost in capture stage");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_vertex.last_vertex) |=> o_valid)
        else $error("gap inside a quad's vertex burst");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_vertex.tex_u <= 17'd65536) && (o_vertex.tex_v <= 17'd65536)))
        else $error("texture coordinate out of range");

endmodule
